// ===== sv/keystore_stream_parser_top_macros.svh =====
// Assertion macros for the key-store stream parser.
// Included by the top level; the bodies compile away when SYNTHESIS is set.
`ifndef KEYSTORE_STREAM_PARSER_TOP_MACROS_SVH
`define KEYSTORE_STREAM_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KSP_ASSERT_IMP(lbl, ante, cons, msg)
`define KSP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/ksp_pkg.sv =====
// Shared types, constants and helper functions of the key-store stream parser.
// No dependencies; imported by every module of the block.
package ksp_pkg;

  localparam int LENGTH_BITS     = 25;
  localparam int SIGNATURE_BYTES = 20;
  localparam int HDR_BYTES       = 12;
  localparam int ENTRY_BYTES     = 24;
  localparam int CFG_W           = 26;
  localparam int OFF_W           = LENGTH_BITS;
  localparam int LEN_W           = (LENGTH_BITS + 1 > CFG_W) ? LENGTH_BITS + 1 : CFG_W;
  localparam int FIT_W           = ((OFF_W > 32) ? OFF_W : 32) + 1;
  localparam int MUL_W           = 32 + 5;
  localparam int ENT_W           = 21;

  localparam logic [31:0] MAGIC      = 32'hfeedfeed;
  localparam logic [31:0] VERSION    = 32'd2;
  localparam logic [31:0] TYPE_KEY   = 32'd1;
  localparam logic [31:0] TYPE_CERT  = 32'd2;

  // field sizes in bytes
  localparam logic [31:0] TYPE_LEN   = 32'd4;
  localparam logic [31:0] ALEN_LEN   = 32'd2;
  localparam logic [31:0] TIME_LEN   = 32'd8;
  localparam logic [31:0] KLEN_LEN   = 32'd4;
  localparam logic [31:0] COUNT_LEN  = 32'd4;
  localparam logic [31:0] TAG_LEN    = 32'd7;
  localparam logic [31:0] CLEN_LEN   = 32'd4;

  typedef enum logic [12:0] {
    PH_HDR   = 13'h0001,
    PH_TYPE  = 13'h0002,
    PH_ALEN  = 13'h0004,
    PH_ALIAS = 13'h0008,
    PH_TIME  = 13'h0010,
    PH_KLEN  = 13'h0020,
    PH_KEY   = 13'h0040,
    PH_COUNT = 13'h0080,
    PH_TAG   = 13'h0100,
    PH_CLEN  = 13'h0200,
    PH_CERT  = 13'h0400,
    PH_DONE  = 13'h0800,
    PH_ERR   = 13'h1000
  } ksp_phase_e;

  typedef enum logic [3:0] {
    CLS_HDR   = 4'd0,
    CLS_TYPE  = 4'd1,
    CLS_ALEN  = 4'd2,
    CLS_ALIAS = 4'd3,
    CLS_TIME  = 4'd4,
    CLS_KLEN  = 4'd5,
    CLS_KEY   = 4'd6,
    CLS_COUNT = 4'd7,
    CLS_TAG   = 4'd8,
    CLS_CLEN  = 4'd9,
    CLS_CERT  = 4'd10,
    CLS_SIG   = 4'd11,
    CLS_ERR   = 4'd12
  } ksp_class_e;

  typedef enum logic [3:0] {
    ST_BUSY        = 4'd0,
    ST_OK          = 4'd1,
    ST_TOO_SMALL   = 4'd2,
    ST_BAD_MAGIC   = 4'd3,
    ST_BAD_VERSION = 4'd4,
    ST_TOO_MANY    = 4'd5,
    ST_BAD_TYPE    = 4'd6,
    ST_BAD_TAG     = 4'd7,
    ST_UNEXP_END   = 4'd8,
    ST_TRAILING    = 4'd9
  } ksp_status_e;

  typedef struct packed {
    logic [LEN_W-1:0] eff_len;
    logic [LEN_W-1:0] data_end;
    logic             too_small;
  } ksp_cfg_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    ksp_class_e       byte_class;
    logic             cert_first;
    logic             cert_last;
    logic [ENT_W-1:0] entry_number;
    ksp_status_e      parse_status;
  } ksp_result_t;

  function automatic ksp_class_e ksp_phase_class(input ksp_phase_e ph);
    ksp_class_e cls;
    unique case (ph)
      PH_HDR:   cls = CLS_HDR;
      PH_TYPE:  cls = CLS_TYPE;
      PH_ALEN:  cls = CLS_ALEN;
      PH_ALIAS: cls = CLS_ALIAS;
      PH_TIME:  cls = CLS_TIME;
      PH_KLEN:  cls = CLS_KLEN;
      PH_KEY:   cls = CLS_KEY;
      PH_COUNT: cls = CLS_COUNT;
      PH_TAG:   cls = CLS_TAG;
      PH_CLEN:  cls = CLS_CLEN;
      PH_CERT:  cls = CLS_CERT;
      PH_DONE:  cls = CLS_SIG;
      default:  cls = CLS_ERR;
    endcase
    return cls;
  endfunction

  // X.509 type tag: 16-bit length 5 followed by "X.509"
  function automatic logic [7:0] ksp_tag_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h00;
      3'd1:    b = 8'h05;
      3'd2:    b = 8'h58;
      3'd3:    b = 8'h2e;
      3'd4:    b = 8'h35;
      3'd5:    b = 8'h30;
      3'd6:    b = 8'h39;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/ksp_cfg.sv =====
// Length register of the key-store stream parser, with the derived limits.
// Depends on ksp_pkg.
module ksp_cfg
  import ksp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] content_length_i,
  output ksp_cfg_t         cfg_o
);

  ksp_cfg_t         cfg_d, cfg_q;
  logic [LEN_W-1:0] len_ext, len_lim, eff;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    len_ext = LEN_W'(content_length_i);
    len_lim = LEN_W'(1) << LENGTH_BITS;
    // clamp to the addressable range
    eff     = (len_ext > len_lim) ? len_lim : len_ext;
    cfg_d.eff_len   = eff;
    cfg_d.data_end  = (eff < LEN_W'(SIGNATURE_BYTES)) ? '0 : eff - LEN_W'(SIGNATURE_BYTES);
    cfg_d.too_small = eff < LEN_W'(HDR_BYTES + SIGNATURE_BYTES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eff_len   <= '0;
      cfg_q.data_end  <= '0;
      cfg_q.too_small <= 1'b1;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/ksp_parser.sv =====
// Phase machine and counters of the key-store stream parser: one byte per step.
// Depends on ksp_pkg; limits come from ksp_cfg.
module ksp_parser
  import ksp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ksp_cfg_t    cfg_i,
  input  logic        step_i,
  input  logic [7:0]  data_byte_i,
  output ksp_result_t res_o
);

  ksp_phase_e       phase_d, phase_q;
  logic [OFF_W-1:0] off_d, off_q, noff;
  logic [31:0]      acc_d, acc_q, acc_sh;
  logic [31:0]      fbl_d, fbl_q, fbl_dec;
  logic [31:0]      total_d, total_q;
  logic [ENT_W-1:0] idx_d, idx_q, idx_inc;
  logic [31:0]      certs_d, certs_q, certs_dec;
  ksp_status_e      status_d, status_q;
  logic             key_d, key_q;

  logic             active, first, last;
  logic             do_enter, do_cert_done, do_finish, do_end, do_fail, load_cert_len;
  ksp_phase_e       enter_ph;
  logic [31:0]      enter_n;
  ksp_status_e      fail_code;
  logic [MUL_W-1:0] count_bytes;
  logic [FIT_W-1:0] fit_sum;

  assign active    = (phase_q != PH_DONE) && (phase_q != PH_ERR);
  assign noff      = (&off_q) ? off_q : off_q + OFF_W'(1);
  assign acc_sh    = {acc_q[23:0], data_byte_i};
  assign fbl_dec   = (fbl_q != '0) ? fbl_q - 32'd1 : '0;
  assign certs_dec = (certs_q != '0) ? certs_q - 32'd1 : '0;
  assign idx_inc   = idx_q + ENT_W'(1);
  assign count_bytes = MUL_W'(acc_sh) * MUL_W'(ENTRY_BYTES);

  always_comb begin
    phase_d  = phase_q;
    off_d    = off_q;
    acc_d    = acc_q;
    fbl_d    = fbl_q;
    total_d  = total_q;
    idx_d    = idx_q;
    certs_d  = certs_q;
    status_d = status_q;
    key_d    = key_q;
    first    = 1'b0;
    last     = 1'b0;
    do_enter      = 1'b0;
    do_cert_done  = 1'b0;
    do_finish     = 1'b0;
    do_end        = 1'b0;
    do_fail       = 1'b0;
    load_cert_len = 1'b0;
    enter_ph      = PH_TYPE;
    enter_n       = '0;
    fail_code     = ST_BUSY;
    fit_sum       = '0;

    if (step_i && active) begin
      off_d = noff;
      if (phase_q != PH_CERT) begin
        acc_d = acc_sh;
      end

      unique case (phase_q)
        PH_HDR: begin
          if ((off_q == '0) && cfg_i.too_small) begin
            do_fail = 1'b1; fail_code = ST_TOO_SMALL;
          end else if ((off_q == OFF_W'(3)) && (acc_sh != MAGIC)) begin
            do_fail = 1'b1; fail_code = ST_BAD_MAGIC;
          end else if ((off_q == OFF_W'(7)) && (acc_sh != VERSION)) begin
            do_fail = 1'b1; fail_code = ST_BAD_VERSION;
          end else if (off_q >= OFF_W'(HDR_BYTES - 1)) begin
            if (count_bytes > MUL_W'(cfg_i.eff_len)) begin
              do_fail = 1'b1; fail_code = ST_TOO_MANY;
            end else begin
              total_d = acc_sh;
              if (acc_sh == '0) begin
                do_end = 1'b1;
              end else begin
                do_enter = 1'b1; enter_ph = PH_TYPE; enter_n = TYPE_LEN;
              end
            end
          end
        end
        PH_TAG: begin
          if (data_byte_i != ksp_tag_byte(3'(3'd7 - fbl_q[2:0]))) begin
            do_fail = 1'b1; fail_code = ST_BAD_TAG;
          end else begin
            fbl_d = fbl_dec;
            if (fbl_dec == '0) begin
              do_enter = 1'b1; enter_ph = PH_CLEN; enter_n = CLEN_LEN;
            end
          end
        end
        default: begin
          fbl_d = fbl_dec;
          if (phase_q == PH_CERT) begin
            first = (fbl_q == acc_q);
            last  = (fbl_q <= 32'd1);
          end
          if (fbl_dec == '0) begin
            unique case (phase_q)
              PH_TYPE: begin
                if ((acc_sh == TYPE_KEY) || (acc_sh == TYPE_CERT)) begin
                  key_d    = (acc_sh == TYPE_KEY);
                  do_enter = 1'b1; enter_ph = PH_ALEN; enter_n = ALEN_LEN;
                end else begin
                  do_fail = 1'b1; fail_code = ST_BAD_TYPE;
                end
              end
              PH_ALEN: begin
                do_enter = 1'b1;
                if (acc_sh[15:0] != '0) begin
                  enter_ph = PH_ALIAS; enter_n = 32'(acc_sh[15:0]);
                end else begin
                  enter_ph = PH_TIME; enter_n = TIME_LEN;
                end
              end
              PH_ALIAS: begin
                do_enter = 1'b1; enter_ph = PH_TIME; enter_n = TIME_LEN;
              end
              PH_TIME: begin
                do_enter = 1'b1;
                if (key_q) begin
                  enter_ph = PH_KLEN; enter_n = KLEN_LEN;
                end else begin
                  certs_d  = 32'd1;
                  enter_ph = PH_TAG; enter_n = TAG_LEN;
                end
              end
              PH_KLEN: begin
                do_enter = 1'b1;
                if (acc_sh != '0) begin
                  enter_ph = PH_KEY; enter_n = acc_sh;
                end else begin
                  enter_ph = PH_COUNT; enter_n = COUNT_LEN;
                end
              end
              PH_KEY: begin
                do_enter = 1'b1; enter_ph = PH_COUNT; enter_n = COUNT_LEN;
              end
              PH_COUNT: begin
                certs_d = acc_sh;
                if (acc_sh != '0) begin
                  do_enter = 1'b1; enter_ph = PH_TAG; enter_n = TAG_LEN;
                end else begin
                  do_finish = 1'b1;
                end
              end
              PH_CLEN: begin
                if (acc_sh != '0) begin
                  do_enter = 1'b1; enter_ph = PH_CERT; enter_n = acc_sh;
                  load_cert_len = 1'b1;
                end else begin
                  do_cert_done = 1'b1;
                end
              end
              PH_CERT: do_cert_done = 1'b1;
              default: ;
            endcase
          end
        end
      endcase

      // one certificate finished: next tag or end of entry
      if (do_cert_done) begin
        certs_d = certs_dec;
        if (certs_dec != '0) begin
          do_enter = 1'b1; enter_ph = PH_TAG; enter_n = TAG_LEN;
        end else begin
          do_finish = 1'b1;
        end
      end

      if (do_finish) begin
        idx_d = idx_inc;
        if (32'(idx_inc) >= total_q) begin
          do_end = 1'b1;
        end else begin
          do_enter = 1'b1; enter_ph = PH_TYPE; enter_n = TYPE_LEN;
        end
      end

      // open the next field; it must end before the signature
      if (do_enter) begin
        phase_d = enter_ph;
        fbl_d   = enter_n;
        acc_d   = load_cert_len ? acc_sh : '0;
        fit_sum = FIT_W'(noff) + FIT_W'(enter_n);
        if (fit_sum > FIT_W'(cfg_i.data_end)) begin
          do_fail = 1'b1; fail_code = ST_UNEXP_END;
        end
      end

      if (do_end) begin
        if (LEN_W'(noff) == cfg_i.data_end) begin
          phase_d  = PH_DONE;
          status_d = ST_OK;
        end else begin
          do_fail = 1'b1; fail_code = ST_TRAILING;
        end
      end

      if (do_fail) begin
        phase_d  = PH_ERR;
        status_d = fail_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR;
      off_q    <= '0;
      acc_q    <= '0;
      fbl_q    <= '0;
      total_q  <= '0;
      idx_q    <= '0;
      certs_q  <= '0;
      status_q <= ST_BUSY;
      key_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      off_q    <= off_d;
      acc_q    <= acc_d;
      fbl_q    <= fbl_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      certs_q  <= certs_d;
      status_q <= status_d;
      key_q    <= key_d;
    end
  end

  always_comb begin
    res_o.out_byte     = data_byte_i;
    res_o.byte_class   = ksp_phase_class(phase_q);
    res_o.cert_first   = first;
    res_o.cert_last    = last;
    res_o.entry_number = idx_q;
    res_o.parse_status = status_d;
  end

endmodule

// ===== sv/keystore_stream_parser_top.sv =====
// Key-store stream parser: takes a version-2 key-store file one byte per request and
// returns one result per byte (the byte, its field class, certificate first/last marks,
// entry number and the sticky parse status). Throughput is one byte per clock while the
// output is not stalled. The byte waits in the input register and the single parse step
// loads the result register from it; a stalled output holds the input register and then
// the input channel. The user must write content_length through the configuration
// channel only while no byte is in flight; the block itself does not enforce this.
// Depends on ksp_pkg, ksp_cfg, ksp_parser and keystore_stream_parser_top_macros.svh.
`include "keystore_stream_parser_top_macros.svh"

module keystore_stream_parser_top
  import ksp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] content_length_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic [3:0]       byte_class_o,
  output logic             cert_first_o,
  output logic             cert_last_o,
  output logic [ENT_W-1:0] entry_number_o,
  output logic [3:0]       parse_status_o
);

  ksp_cfg_t    cfg;
  ksp_result_t res_d, res_q;
  logic        in_valid_d, in_valid_q;
  logic [7:0]  byte_q;
  logic        out_valid_d, out_valid_q;
  logic        adv;

  ksp_cfg u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .content_length_i (content_length_i),
    .cfg_o            (cfg)
  );

  // parse the held byte whenever the result register is free or being drained
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  ksp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (adv),
    .data_byte_i (byte_q),
    .res_o       (res_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = res_q.out_byte;
  assign byte_class_o   = res_q.byte_class;
  assign cert_first_o   = res_q.cert_first;
  assign cert_last_o    = res_q.cert_last;
  assign entry_number_o = res_q.entry_number;
  assign parse_status_o = res_q.parse_status;

  `KSP_ASSERT_IMP(a_cert_mark_class, out_valid_o && (cert_first_o || cert_last_o), byte_class_o == CLS_CERT, "certificate mark outside certificate data")
  `KSP_ASSERT_IMP(a_stall_cause, !in_ready_o, in_valid_q && out_valid_q && !out_ready_i, "input stalled without a full pipeline")
  `KSP_ASSERT_NXT(a_result_follows, adv, out_valid_o, "parsed request produced no result")

endmodule
